// ===== src/tsc_pkg.sv =====
package tsc_pkg;

    // scanner states
    typedef enum logic [3:0] {
        S_H, S_IDENT, S_NUMB, S_COM, S_ALE, S_NEQ, S_COM1, S_COM2, S_STR
    } t_scan;

    // controller states
    typedef enum logic [2:0] {
        C_IDLE, C_STEP, C_FIN, C_KW, C_RD, C_CMP, C_INS
    } t_ctl;

    // datapath commands
    typedef enum logic [2:0] {
        CMD_NONE, CMD_LOAD, CMD_STEP, CMD_FIN, CMD_KW, CMD_RD, CMD_CMP, CMD_INS
    } t_cmd;

    typedef struct packed {
        logic word_end;
        logic rescan;
        logic fin_next;
        logic kw_hit;
        logic idx_done;
        logic cmp_hit;
        logic table_full;
        logic eot;
        logic halted;
    } t_stat;

    typedef struct packed {
        logic [7:0] in_char;
        logic       end_of_text;
    } t_item;

    typedef struct packed {
        logic [1:0]  out_kind;
        logic [5:0]  token_code;
        logic [30:0] token_value;
        logic [7:0]  text_char;
        logic [2:0]  error_code;
        logic        number_overflow;
        logic        last;
    } t_res;

    localparam logic [1:0] K_TOKEN = 2'd0;
    localparam logic [1:0] K_CHAR  = 2'd1;
    localparam logic [1:0] K_ERROR = 2'd2;

    localparam logic [5:0] T_NONE  = 6'd0;
    localparam logic [5:0] T_FIN   = 6'd21;
    localparam logic [5:0] T_NUM   = 6'd41;
    localparam logic [5:0] T_ID    = 6'd42;
    localparam logic [5:0] T_STR   = 6'd43;
    localparam logic [5:0] T_DELIM = 6'd21;

    localparam logic [2:0] E_UNCLOSED = 3'd1;
    localparam logic [2:0] E_SYMBOL   = 3'd2;
    localparam logic [2:0] E_BANG     = 3'd3;
    localparam logic [2:0] E_LONG     = 3'd4;
    localparam logic [2:0] E_FULL     = 3'd5;

    localparam logic [4:0] D_EQ    = 5'd4;
    localparam logic [4:0] D_EQEQ  = 5'd7;
    localparam logic [4:0] D_LT    = 5'd8;
    localparam logic [4:0] D_GT    = 5'd9;
    localparam logic [4:0] D_SLASH = 5'd15;
    localparam logic [4:0] D_LE    = 5'd16;
    localparam logic [4:0] D_NE    = 5'd17;
    localparam logic [4:0] D_GE    = 5'd18;

    localparam logic [30:0] NUM_MAX = 31'h7FFF_FFFF;
    localparam int          KW_NUM  = 20;

    localparam logic [55:0] KW_STR [KW_NUM] = '{
        "and", "break", "bool", "do", "else", "if", "false", "int", "not", "or",
        "program", "read", "then", "true", "while", "write", "string", "for",
        "goto", "struct"
    };
    localparam logic [2:0] KW_LEN [KW_NUM] = '{
        3'd3, 3'd5, 3'd4, 3'd2, 3'd4, 3'd2, 3'd5, 3'd3, 3'd3, 3'd2,
        3'd7, 3'd4, 3'd4, 3'd4, 3'd5, 3'd5, 3'd6, 3'd3, 3'd4, 3'd6
    };

    function automatic logic [7:0] kw_char(input int i, input int k);
        int base;
        base = 8 * (int'(KW_LEN[i]) - 1 - k);
        if (k < int'(KW_LEN[i])) return KW_STR[i][base +: 8];
        return 8'd0;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic [4:0] delim_index(input logic [7:0] c);
        unique case (c)
            ";":     return 5'd1;
            ",":     return 5'd2;
            ":":     return 5'd3;
            "(":     return 5'd5;
            ")":     return 5'd6;
            "+":     return 5'd10;
            "-":     return 5'd11;
            "{":     return 5'd12;
            "}":     return 5'd13;
            "*":     return 5'd14;
            ".":     return 5'd19;
            default: return 5'd0;
        endcase
    endfunction

    // true when the start state gives a result for this character
    function automatic logic h_emits(input logic [7:0] c);
        return !(c == " " || c == 8'd10 || c == 8'd13 || c == 8'd9 || is_alpha(c)
                 || is_digit(c) || c == "/" || c == "=" || c == "<" || c == ">"
                 || c == "!" || c == "\"");
    endfunction

    function automatic logic [4:0] single_rel(input logic [7:0] c);
        return (c == "=") ? D_EQ : ((c == "<") ? D_LT : D_GT);
    endfunction

endpackage

// ===== src/token_scanner_unit.sv =====
// channel | direction | handshake              | payload
// input   | in        | i_in_valid/o_in_ready  | i_in_data  (tsc_pkg::t_item)
// output  | out       | o_out_valid/i_out_ready| o_out_data (tsc_pkg::t_res)
//
// A character is accepted and then takes one scan step, plus one step per
// rescan; ending an identifier adds a keyword check and a walk over the
// stored names in the name table, reading and comparing one row at a time,
// then an insertion for a new name. End of text adds a FIN step.
// Reset is synchronous and empties the name table at once through its fill
// count. Results wait in a four-entry queue, so a new character is taken
// while up to two results still wait.
module token_scanner_unit #(
    parameter int ID_DEPTH = 64,
    parameter int ID_LEN   = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  tsc_pkg::t_item i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output tsc_pkg::t_res  o_out_data
);
    import tsc_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    t_res  res;
    logic  push, pop, idle, in_fire;

    t_res       r_q [4];
    logic [1:0] r_wr, r_rd;
    logic [2:0] r_cnt;

    assign in_fire     = i_in_valid && o_in_ready;
    assign o_in_ready  = idle && (r_cnt <= 3'd2);
    assign o_out_valid = (r_cnt != 3'd0);
    assign o_out_data  = r_q[r_rd];
    assign pop         = o_out_valid && i_out_ready;

    tsc_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_fire (in_fire),
        .i_stat (stat),
        .o_cmd  (cmd),
        .o_idle (idle)
    );

    tsc_dp #(
        .ID_DEPTH(ID_DEPTH),
        .ID_LEN  (ID_LEN)
    ) u_dp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd),
        .i_item (i_in_data),
        .o_stat (stat),
        .o_push (push),
        .o_res  (res)
    );

    // queue results toward the output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wr <= r_wr + 2'd1;
            if (pop)  r_rd <= r_rd + 2'd1;
            r_cnt <= r_cnt + {2'd0, push} - {2'd0, pop};
        end
        if (push) r_q[r_wr] <= res;
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (r_cnt != 3'd4) || pop)
        else $error("result queue overflow");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && !stat.halted) |=> !idle)
        else $error("accepted transaction not started");

    a_halt_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.halted |=> stat.halted)
        else $error("halt released without reset");

    a_push_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !idle)
        else $error("result pushed while idle");

endmodule

// ===== src/tsc_ctrl.sv =====
module tsc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_fire,
    input  tsc_pkg::t_stat i_stat,
    output tsc_pkg::t_cmd  o_cmd,
    output logic          o_idle
);
    import tsc_pkg::*;

    t_ctl r_state, n_state;

    // hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // sequence one character through the datapath
    always_comb begin
        n_state = r_state;
        o_cmd   = CMD_NONE;
        o_idle  = (r_state == C_IDLE);
        unique case (r_state)
            C_IDLE: begin
                if (i_fire && !i_stat.halted) begin
                    o_cmd   = CMD_LOAD;
                    n_state = C_STEP;
                end
            end
            C_STEP: begin
                if (i_stat.word_end) begin
                    n_state = C_KW;
                end else begin
                    o_cmd = CMD_STEP;
                    if (i_stat.rescan)        n_state = C_STEP;
                    else if (i_stat.fin_next) n_state = C_FIN;
                    else                      n_state = C_IDLE;
                end
            end
            C_FIN: begin
                o_cmd   = CMD_FIN;
                n_state = C_IDLE;
            end
            C_KW: begin
                o_cmd = CMD_KW;
                if (!i_stat.kw_hit)    n_state = C_RD;
                else if (i_stat.eot)   n_state = C_FIN;
                else                   n_state = C_STEP;
            end
            C_RD: begin
                if (i_stat.idx_done) begin
                    n_state = C_INS;
                end else begin
                    o_cmd   = CMD_RD;
                    n_state = C_CMP;
                end
            end
            C_CMP: begin
                o_cmd = CMD_CMP;
                if (!i_stat.cmp_hit)  n_state = C_RD;
                else if (i_stat.eot)  n_state = C_FIN;
                else                  n_state = C_STEP;
            end
            C_INS: begin
                o_cmd = CMD_INS;
                if (i_stat.table_full) n_state = C_IDLE;
                else if (i_stat.eot)   n_state = C_FIN;
                else                   n_state = C_STEP;
            end
            default: n_state = C_IDLE;
        endcase
    end

endmodule

// ===== src/tsc_dp.sv =====
module tsc_dp #(
    parameter int ID_DEPTH = 64,
    parameter int ID_LEN   = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tsc_pkg::t_cmd  i_cmd,
    input  tsc_pkg::t_item i_item,
    output tsc_pkg::t_stat o_stat,
    output logic           o_push,
    output tsc_pkg::t_res  o_res
);
    import tsc_pkg::*;

    localparam int CW = $clog2(ID_DEPTH + 1);
    localparam int IW = $clog2(ID_DEPTH);
    localparam int LW = $clog2(ID_LEN + 1);
    localparam int XW = $clog2(ID_LEN);
    localparam int RW = LW + 8 * ID_LEN;

    t_scan                    r_state, n_state;
    logic [ID_LEN-1:0][7:0]   r_word, n_word;
    logic [LW-1:0]            r_len, n_len;
    logic [30:0]              r_acc, n_acc;
    logic                     r_ovf, n_ovf;
    logic [CW-1:0]            r_count, n_count;
    logic [CW-1:0]            r_idx, n_idx;
    logic                     r_halted, n_halted;
    logic [7:0]               r_char, n_char;
    logic                     r_eot, n_eot;
    logic [RW-1:0]            r_row;
    logic [RW-1:0]            r_mem [ID_DEPTH];
    logic                     mem_we;

    logic       kw_hit, cmp_hit, word_last;
    logic [4:0] kw_idx;
    logic [34:0] acc_next;
    logic [7:0] c;

    assign c = r_char;

    // match the word against the keyword table
    always_comb begin
        logic eq;
        kw_hit = 1'b0;
        kw_idx = 5'd0;
        for (int i = KW_NUM - 1; i >= 0; i--) begin
            eq = (int'(r_len) == int'(KW_LEN[i]));
            for (int k = 0; k < 7; k++) begin
                if (k < int'(KW_LEN[i]))
                    eq = eq && (r_word[k % ID_LEN] == kw_char(i, k));
            end
            if (eq) begin
                kw_hit = 1'b1;
                kw_idx = 5'(i + 1);
            end
        end
    end

    // match the word against the name table row just read
    always_comb begin
        cmp_hit = (r_row[RW-1 -: LW] == r_len);
        for (int k = 0; k < ID_LEN; k++) begin
            if (k < int'(r_len))
                cmp_hit = cmp_hit && (r_row[8*k +: 8] == r_word[k]);
        end
    end

    assign acc_next  = {1'b0, r_acc, 3'b0} + {3'b0, r_acc, 1'b0} + {27'd0, c - 8'd48};
    assign word_last = r_eot ? 1'b0 : !h_emits(c);

    always_comb begin
        o_stat.word_end   = (r_state == S_IDENT) && (r_eot || !(is_alpha(c) || is_digit(c)));
        o_stat.rescan     = !r_eot && (((r_state == S_NUMB) && !is_digit(c))
                            || ((r_state == S_COM1) && c != "*")
                            || ((r_state == S_ALE) && c != "="));
        o_stat.fin_next   = r_eot && (r_state == S_H || r_state == S_NUMB
                            || r_state == S_COM1 || r_state == S_ALE);
        o_stat.kw_hit     = kw_hit;
        o_stat.idx_done   = (r_idx == r_count);
        o_stat.cmp_hit    = cmp_hit;
        o_stat.table_full = (r_count == CW'(ID_DEPTH));
        o_stat.eot        = r_eot;
        o_stat.halted     = r_halted;
    end

    // next state and result for each command
    always_comb begin
        n_state  = r_state;
        n_word   = r_word;
        n_len    = r_len;
        n_acc    = r_acc;
        n_ovf    = r_ovf;
        n_count  = r_count;
        n_idx    = r_idx;
        n_halted = r_halted;
        n_char   = r_char;
        n_eot    = r_eot;
        mem_we   = 1'b0;
        o_push   = 1'b0;
        o_res    = '0;
        unique case (i_cmd)
            CMD_NONE: ;
            CMD_LOAD: begin
                n_char = i_item.in_char;
                n_eot  = i_item.end_of_text;
            end
            CMD_STEP: begin
                if (r_eot) begin
                    unique case (r_state)
                        S_H, S_IDENT: ;
                        S_NUMB: begin
                            o_push = 1'b1;
                            o_res.token_code      = T_NUM;
                            o_res.token_value     = r_acc;
                            o_res.number_overflow = r_ovf;
                        end
                        S_COM1: begin
                            o_push = 1'b1;
                            o_res.token_code  = T_DELIM + 6'(D_SLASH);
                            o_res.token_value = 31'(D_SLASH);
                        end
                        S_ALE: begin
                            o_push = 1'b1;
                            o_res.token_code  = T_DELIM + 6'(single_rel(r_word[0]));
                            o_res.token_value = 31'(single_rel(r_word[0]));
                        end
                        S_NEQ: begin
                            o_push = 1'b1;
                            o_res.out_kind   = K_ERROR;
                            o_res.error_code = E_BANG;
                            o_res.last       = 1'b1;
                            n_halted         = 1'b1;
                        end
                        default: begin
                            o_push = 1'b1;
                            o_res.out_kind   = K_ERROR;
                            o_res.error_code = E_UNCLOSED;
                            o_res.last       = 1'b1;
                            n_halted         = 1'b1;
                        end
                    endcase
                end else begin
                    unique case (r_state)
                        S_H: begin
                            if (c == " " || c == 8'd10 || c == 8'd13 || c == 8'd9) begin
                            end else if (is_alpha(c)) begin
                                n_word[0] = c;
                                n_len     = LW'(1);
                                n_state   = S_IDENT;
                            end else if (is_digit(c)) begin
                                n_acc   = 31'(c - 8'd48);
                                n_ovf   = 1'b0;
                                n_state = S_NUMB;
                            end else if (c == "/") begin
                                n_state = S_COM1;
                            end else if (c == "=" || c == "<" || c == ">") begin
                                n_word[0] = c;
                                n_len     = LW'(1);
                                n_state   = S_ALE;
                            end else if (c == "!") begin
                                n_state = S_NEQ;
                            end else if (c == "\"") begin
                                n_state = S_STR;
                            end else begin
                                o_push     = 1'b1;
                                o_res.last = 1'b1;
                                if (delim_index(c) != 5'd0) begin
                                    o_res.token_code  = T_DELIM + 6'(delim_index(c));
                                    o_res.token_value = 31'(delim_index(c));
                                end else begin
                                    o_res.out_kind   = K_ERROR;
                                    o_res.error_code = E_SYMBOL;
                                    n_halted         = 1'b1;
                                end
                            end
                        end
                        S_STR: begin
                            o_push           = 1'b1;
                            o_res.last       = 1'b1;
                            o_res.token_code = T_STR;
                            if (c != "\"") begin
                                o_res.out_kind  = K_CHAR;
                                o_res.text_char = c;
                            end else begin
                                n_state = S_H;
                            end
                        end
                        S_IDENT: begin
                            if (is_alpha(c) || is_digit(c)) begin
                                if (int'(r_len) >= ID_LEN) begin
                                    o_push = 1'b1;
                                    o_res.out_kind   = K_ERROR;
                                    o_res.error_code = E_LONG;
                                    o_res.last       = 1'b1;
                                    n_halted         = 1'b1;
                                end else begin
                                    n_word[r_len[XW-1:0]] = c;
                                    n_len = r_len + LW'(1);
                                end
                            end
                        end
                        S_NUMB: begin
                            if (is_digit(c)) begin
                                if (acc_next > {4'd0, NUM_MAX}) begin
                                    n_acc = NUM_MAX;
                                    n_ovf = 1'b1;
                                end else begin
                                    n_acc = acc_next[30:0];
                                end
                            end else begin
                                o_push = 1'b1;
                                o_res.token_code      = T_NUM;
                                o_res.token_value     = r_acc;
                                o_res.number_overflow = r_ovf;
                                o_res.last            = !h_emits(c);
                                n_state               = S_H;
                            end
                        end
                        S_COM1: begin
                            if (c == "*") begin
                                n_state = S_COM;
                            end else begin
                                o_push = 1'b1;
                                o_res.token_code  = T_DELIM + 6'(D_SLASH);
                                o_res.token_value = 31'(D_SLASH);
                                o_res.last        = !h_emits(c);
                                n_state           = S_H;
                            end
                        end
                        S_COM2: begin
                            if (c == "/")      n_state = S_H;
                            else if (c != "*") n_state = S_COM;
                        end
                        S_COM: begin
                            if (c == "*") n_state = S_COM2;
                        end
                        S_ALE: begin
                            o_push  = 1'b1;
                            n_state = S_H;
                            n_len   = '0;
                            if (c == "=") begin
                                priority if (r_word[0] == "=") begin
                                    o_res.token_code  = T_DELIM + 6'(D_EQEQ);
                                    o_res.token_value = 31'(D_EQEQ);
                                end else if (r_word[0] == "<") begin
                                    o_res.token_code  = T_DELIM + 6'(D_LE);
                                    o_res.token_value = 31'(D_LE);
                                end else begin
                                    o_res.token_code  = T_DELIM + 6'(D_GE);
                                    o_res.token_value = 31'(D_GE);
                                end
                                o_res.last = 1'b1;
                            end else begin
                                o_res.token_code  = T_DELIM + 6'(single_rel(r_word[0]));
                                o_res.token_value = 31'(single_rel(r_word[0]));
                                o_res.last        = !h_emits(c);
                            end
                        end
                        S_NEQ: begin
                            o_push     = 1'b1;
                            o_res.last = 1'b1;
                            if (c == "=") begin
                                o_res.token_code  = T_DELIM + 6'(D_NE);
                                o_res.token_value = 31'(D_NE);
                                n_state           = S_H;
                            end else begin
                                o_res.out_kind   = K_ERROR;
                                o_res.error_code = E_BANG;
                                n_halted         = 1'b1;
                            end
                        end
                        default: n_state = S_H;
                    endcase
                end
            end
            CMD_FIN: begin
                o_push           = 1'b1;
                o_res.token_code = T_FIN;
                o_res.last       = 1'b1;
                n_halted         = 1'b1;
                n_state          = S_H;
                n_len            = '0;
            end
            CMD_KW: begin
                n_idx = '0;
                if (kw_hit) begin
                    o_push = 1'b1;
                    o_res.token_code  = 6'(kw_idx);
                    o_res.token_value = 31'(kw_idx);
                    o_res.last        = word_last;
                    n_state           = S_H;
                    n_len             = '0;
                end
            end
            CMD_RD: ;
            CMD_CMP: begin
                if (cmp_hit) begin
                    o_push = 1'b1;
                    o_res.token_code  = T_ID;
                    o_res.token_value = 31'(r_idx);
                    o_res.last        = word_last;
                    n_state           = S_H;
                    n_len             = '0;
                end else begin
                    n_idx = r_idx + CW'(1);
                end
            end
            CMD_INS: begin
                o_push = 1'b1;
                o_res.last = 1'b1;
                if (r_count == CW'(ID_DEPTH)) begin
                    o_res.out_kind   = K_ERROR;
                    o_res.error_code = E_FULL;
                    n_halted         = 1'b1;
                end else begin
                    mem_we            = 1'b1;
                    o_res.token_code  = T_ID;
                    o_res.token_value = 31'(r_count);
                    o_res.last        = word_last;
                    n_count           = r_count + CW'(1);
                    n_state           = S_H;
                    n_len             = '0;
                end
            end
            default: ;
        endcase
    end

    // hold scanner registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_H;
            r_len    <= '0;
            r_acc    <= '0;
            r_ovf    <= 1'b0;
            r_count  <= '0;
            r_halted <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_len    <= n_len;
            r_acc    <= n_acc;
            r_ovf    <= n_ovf;
            r_count  <= n_count;
            r_halted <= n_halted;
        end
        r_word <= n_word;
        r_idx  <= n_idx;
        r_char <= n_char;
        r_eot  <= n_eot;
    end

    // name table: one row per name, length over characters
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[r_count[IW-1:0]] <= {r_len, r_word};
        if (i_cmd == CMD_RD) r_row <= r_mem[r_idx[IW-1:0]];
    end

endmodule

// ===== test/token_scanner_chk.sv =====
module token_scanner_chk (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_ready,
    input  tsc_pkg::t_item i_in_data,
    input  logic           i_out_valid,
    input  logic           i_out_ready,
    input  tsc_pkg::t_res  i_out_data,
    output int             o_fail_count,
    output int             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import tsc_pkg::*;

    localparam int NAME_DEPTH = 64;
    localparam int NAME_LEN   = 16;

    string kw_words [20] = '{
        "and", "break", "bool", "do", "else", "if", "false", "int", "not", "or",
        "program", "read", "then", "true", "while", "write", "string", "for",
        "goto", "struct"
    };

    // predicted scanner state
    t_scan      lex_state;
    logic [7:0] word_buf [NAME_LEN];
    int         word_len;
    logic [30:0] num_acc;
    logic       num_sat;
    string      name_tab [$];
    logic       stopped;

    t_res       step_tokens [$];
    t_res       expected_tokens [$];
    int         mismatches;

    assign o_fail_count = mismatches;

    function automatic logic letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic [4:0] delim_of(input logic [7:0] c);
        case (c)
            ";": return 5'd1;
            ",": return 5'd2;
            ":": return 5'd3;
            "(": return 5'd5;
            ")": return 5'd6;
            "+": return 5'd10;
            "-": return 5'd11;
            "{": return 5'd12;
            "}": return 5'd13;
            "*": return 5'd14;
            ".": return 5'd19;
            default: return 5'd0;
        endcase
    endfunction

    function automatic logic [4:0] rel_of(input logic [7:0] c);
        return (c == "=") ? D_EQ : ((c == "<") ? D_LT : D_GT);
    endfunction

    function automatic void put_tok(input logic [1:0] k, input logic [5:0] code,
                                    input logic [30:0] v, input logic [7:0] ch,
                                    input logic [2:0] e, input logic o);
        t_res r;
        r = '{k, code, v, ch, e, o, 1'b0};
        if (step_tokens.size() < 2) step_tokens.insert(step_tokens.size(), r);
    endfunction

    function automatic void raise_err(input logic [2:0] e);
        put_tok(K_ERROR, T_NONE, '0, '0, e, 1'b0);
        stopped = 1'b1;
    endfunction

    function automatic void put_delim(input logic [4:0] d);
        put_tok(K_TOKEN, T_DELIM + 6'(d), 31'(d), '0, '0, 1'b0);
    endfunction

    // resolve a finished word: keyword, known name, or new name
    function automatic void close_word();
        string w;
        w = "";
        for (int i = 0; i < word_len; i++) w = $sformatf("%s%c", w, word_buf[i]);
        for (int i = 0; i < 20; i++) begin
            if (w == kw_words[i]) begin
                put_tok(K_TOKEN, 6'(i + 1), 31'(i + 1), '0, '0, 1'b0);
                return;
            end
        end
        foreach (name_tab[i]) begin
            if (name_tab[i] == w) begin
                put_tok(K_TOKEN, T_ID, 31'(i), '0, '0, 1'b0);
                return;
            end
        end
        if (name_tab.size() >= NAME_DEPTH) begin
            raise_err(E_FULL);
            return;
        end
        name_tab.insert(name_tab.size(), w);
        put_tok(K_TOKEN, T_ID, 31'(name_tab.size() - 1), '0, '0, 1'b0);
    endfunction

    // advance the scanner by one character; return 1 to rescan it
    function automatic logic scan_char(input logic [7:0] c);
        longint v;
        logic [4:0] d;
        case (lex_state)
            S_H: begin
                if (c == " " || c == 8'd10 || c == 8'd13 || c == 8'd9) begin
                end else if (letter(c)) begin
                    word_buf[0] = c;
                    word_len = 1;
                    lex_state = S_IDENT;
                end else if (digit(c)) begin
                    num_acc = 31'(c - 8'd48);
                    num_sat = 1'b0;
                    lex_state = S_NUMB;
                end else if (c == "/") begin
                    lex_state = S_COM1;
                end else if (c == "=" || c == "<" || c == ">") begin
                    word_buf[0] = c;
                    word_len = 1;
                    lex_state = S_ALE;
                end else if (c == "!") begin
                    lex_state = S_NEQ;
                end else if (c == 8'd34) begin
                    lex_state = S_STR;
                end else begin
                    d = delim_of(c);
                    if (d != 0) put_delim(d);
                    else raise_err(E_SYMBOL);
                end
                return 1'b0;
            end
            S_STR: begin
                if (c != 8'd34) begin
                    put_tok(K_CHAR, T_STR, '0, c, '0, 1'b0);
                end else begin
                    put_tok(K_TOKEN, T_STR, '0, '0, '0, 1'b0);
                    lex_state = S_H;
                end
                return 1'b0;
            end
            S_IDENT: begin
                if (letter(c) || digit(c)) begin
                    if (word_len >= NAME_LEN) begin
                        raise_err(E_LONG);
                    end else begin
                        word_buf[word_len] = c;
                        word_len++;
                    end
                    return 1'b0;
                end
                close_word();
                word_len = 0;
                lex_state = S_H;
                return !stopped;
            end
            S_NUMB: begin
                if (digit(c)) begin
                    v = longint'(num_acc) * 10 + longint'(c - 8'd48);
                    if (v > longint'(NUM_MAX)) begin
                        v = longint'(NUM_MAX);
                        num_sat = 1'b1;
                    end
                    num_acc = 31'(v);
                    return 1'b0;
                end
                put_tok(K_TOKEN, T_NUM, num_acc, '0, '0, num_sat);
                lex_state = S_H;
                return 1'b1;
            end
            S_COM1: begin
                if (c == "*") begin
                    lex_state = S_COM;
                    return 1'b0;
                end
                put_delim(D_SLASH);
                lex_state = S_H;
                return 1'b1;
            end
            S_COM2: begin
                if (c == "/") lex_state = S_H;
                else if (c != "*") lex_state = S_COM;
                return 1'b0;
            end
            S_COM: begin
                if (c == "*") lex_state = S_COM2;
                return 1'b0;
            end
            S_ALE: begin
                lex_state = S_H;
                word_len = 0;
                if (c == "=") begin
                    d = (word_buf[0] == "=") ? D_EQEQ : ((word_buf[0] == "<") ? D_LE : D_GE);
                    put_delim(d);
                    return 1'b0;
                end
                put_delim(rel_of(word_buf[0]));
                return 1'b1;
            end
            S_NEQ: begin
                if (c == "=") begin
                    put_delim(D_NE);
                    lex_state = S_H;
                end else begin
                    raise_err(E_BANG);
                end
                return 1'b0;
            end
            default: begin
                lex_state = S_H;
                return 1'b1;
            end
        endcase
    endfunction

    // flush whatever is pending, then FIN unless an error came up
    function automatic void close_text();
        case (lex_state)
            S_H: ;
            S_IDENT: close_word();
            S_NUMB: put_tok(K_TOKEN, T_NUM, num_acc, '0, '0, num_sat);
            S_COM1: put_delim(D_SLASH);
            S_ALE: put_delim(rel_of(word_buf[0]));
            S_NEQ: raise_err(E_BANG);
            default: raise_err(E_UNCLOSED);
        endcase
        if (!stopped) put_tok(K_TOKEN, T_FIN, '0, '0, '0, 1'b0);
        stopped = 1'b1;
        lex_state = S_H;
        word_len = 0;
    endfunction

    function automatic void lex_step(input t_item it);
        t_res r;
        if (stopped) return;
        step_tokens.delete();
        if (it.end_of_text) close_text();
        else if (scan_char(it.in_char) && !stopped) void'(scan_char(it.in_char));
        if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
        foreach (step_tokens[i]) begin
            r = step_tokens[i];
            expected_tokens.insert(expected_tokens.size(), r);
        end
    endfunction

    function automatic void check_field(input string f, input longint e, input longint a);
        if (e != a) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, f, e, a);
            mismatches++;
        end
    endfunction

    // compare each output transaction, then predict from the input transaction
    always @(posedge i_clk) begin
        t_res e;
        if (!i_rst_n) begin
            lex_state  = S_H;
            word_len   = 0;
            num_acc    = '0;
            num_sat    = 1'b0;
            stopped    = 1'b0;
            name_tab.delete();
            expected_tokens.delete();
            mismatches = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_tokens.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %p",
                             $time, i_out_data);
                    mismatches++;
                end else begin
                    e = expected_tokens.pop_front();
                    check_field("out_kind", e.out_kind, i_out_data.out_kind);
                    check_field("token_code", e.token_code, i_out_data.token_code);
                    check_field("token_value", e.token_value, i_out_data.token_value);
                    check_field("text_char", e.text_char, i_out_data.text_char);
                    check_field("error_code", e.error_code, i_out_data.error_code);
                    check_field("number_overflow", e.number_overflow,
                                i_out_data.number_overflow);
                    check_field("last", e.last, i_out_data.last);
                end
            end
            if (i_in_valid && i_in_ready) lex_step(i_in_data);
        end
        o_pending <= expected_tokens.size();
    end

endmodule

// ===== test/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tsc_pkg::*;

    logic  i_clk;
    logic  i_rst_n;
    logic  i_in_valid;
    logic  o_in_ready;
    t_item i_in_data;
    logic  o_out_valid;
    logic  i_out_ready;
    t_res  o_out_data;
    int    fail_count;
    int    pending;

    t_item source_text [$];
    string name_pool [30];
    string kw_list [20] = '{
        "and", "break", "bool", "do", "else", "if", "false", "int", "not", "or",
        "program", "read", "then", "true", "while", "write", "string", "for",
        "goto", "struct"
    };
    string delims = ";,:()+-{}*.";

    token_scanner_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    token_scanner_chk u_chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_out_data  (o_out_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9");
    endfunction

    function automatic logic [7:0] rand_alnum();
        int r;
        r = $urandom_range(0, 61);
        if (r < 26) return 8'("a" + r);
        if (r < 52) return 8'("A" + r - 26);
        return 8'("0" + r - 52);
    endfunction

    function automatic void push_char(input logic [7:0] c);
        source_text.insert(source_text.size(), '{c, 1'b0});
    endfunction

    function automatic void push_str(input string s);
        for (int i = 0; i < s.len(); i++) push_char(s[i]);
    endfunction

    // append a token, with a space where it would otherwise merge with the last one
    function automatic void push_token(input string s);
        logic [7:0] prev;
        if (source_text.size() > 0 && s.len() > 0) begin
            prev = source_text[source_text.size() - 1].in_char;
            if ((is_alnum(prev) && is_alnum(s[0])) || (prev == "/" && s[0] == "*"))
                push_char(" ");
        end
        push_str(s);
    endfunction

    function automatic void push_comment();
        logic [7:0] c, prev;
        int n;
        push_token("/*");
        prev = "*";
        prev = 8'd0;
        n = $urandom_range(0, 8);
        for (int i = 0; i < n; i++) begin
            c = ($urandom_range(0, 5) == 0) ? 8'("*") : 8'($urandom_range(0, 255));
            if (prev == "*" && c == "/") c = "x";
            push_char(c);
            prev = c;
        end
        push_str("*/");
    endfunction

    function automatic void push_string_lit();
        logic [7:0] c;
        int n;
        push_token("\"");
        n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++) begin
            c = 8'($urandom_range(0, 255));
            if (c == 8'd34) c = 8'd35;
            push_char(c);
        end
        push_char(8'd34);
    endfunction

    function automatic string rand_number();
        string s;
        int n;
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 5);
        s = "";
        for (int i = 0; i < n; i++) s = $sformatf("%s%0d", s, $urandom_range(0, 9));
        return s;
    endfunction

    function automatic void push_eot();
        source_text.insert(source_text.size(), '{8'($urandom_range(0, 255)), 1'b1});
    endfunction

    // well-formed program text with random content
    function automatic void build_body(input int target);
        string s;
        int n;
        while (source_text.size() < target) begin
            case ($urandom_range(0, 11))
                0, 1: push_token(kw_list[$urandom_range(0, 19)]);
                2, 3: push_token(name_pool[$urandom_range(0, 29)]);
                4: push_token(rand_number());
                5: begin
                    n = $urandom_range(0, delims.len() - 1);
                    push_token(delims.substr(n, n));
                end
                6: begin
                    case ($urandom_range(0, 2))
                        0: s = "=";
                        1: s = "<";
                        default: s = ">";
                    endcase
                    if ($urandom_range(0, 1)) s = {s, "="};
                    push_token(s);
                end
                7: push_token("!=");
                8: push_token("/");
                9: push_comment();
                10: push_string_lit();
                default: begin
                    case ($urandom_range(0, 3))
                        0: push_char(" ");
                        1: push_char(8'd9);
                        2: push_char(8'd10);
                        default: push_char(8'd13);
                    endcase
                end
            endcase
        end
    endfunction

    // one way to halt the scanner, then some ignored characters
    function automatic void build_ending();
        string s;
        case ($urandom_range(0, 9))
            0: push_eot();
            1: begin
                push_token("tail9");
                push_eot();
            end
            2: begin
                push_token("/* open");
                push_eot();
            end
            3: begin
                push_token("\"open");
                push_eot();
            end
            4: push_token("!a");
            5: begin
                push_token("!");
                push_eot();
            end
            6: push_char(($urandom_range(0, 1)) ? 8'("@") : 8'($urandom_range(128, 255)));
            7: push_token("abcdefghijklmnopq");
            8: begin
                for (int i = 0; i < 70; i++) push_token($sformatf("ZZ%0d ", i));
            end
            default: begin
                case ($urandom_range(0, 3))
                    0: s = "8";
                    1: s = "<";
                    2: s = "/";
                    default: s = "2147483648";
                endcase
                push_token(s);
                push_eot();
            end
        endcase
        for (int i = 0; i < 5; i++) begin
            if ($urandom_range(0, 1)) push_eot();
            else push_char(8'($urandom_range(0, 255)));
        end
    endfunction

    function automatic int rand_gap();
        if ($urandom_range(0, 9) < 6) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result-side stalls: long ready stretches, short stalls, rare long ones
    initial begin
        int run;
        i_out_ready = 1'b0;
        run = 0;
        forever begin
            @(negedge i_clk);
            if (run == 0) begin
                if (!i_out_ready) begin
                    i_out_ready <= 1'b1;
                    run = $urandom_range(1, 30);
                end else begin
                    i_out_ready <= 1'b0;
                    run = rand_gap() + 1;
                end
            end
            run--;
        end
    end

    initial begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int n;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;

        // names reused all through the body so the table never fills early
        foreach (name_pool[i]) begin
            name_pool[i] = $sformatf("%c", 8'("a" + $urandom_range(0, 25)));
            n = $urandom_range(0, 15);
            for (int k = 0; k < n; k++)
                name_pool[i] = $sformatf("%s%c", name_pool[i], rand_alnum());
        end

        // directed: keyword, name, two-char relation, saturating number,
        // slash with rescans, string with the extreme bytes
        push_str("while v<=4294967299/q;");
        push_char(8'd34);
        push_char(8'h00);
        push_char(8'hFF);
        push_char(8'd34);
        build_body(1050);
        build_ending();

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (source_text[i]) begin
            n = rand_gap();
            if (n > 0) begin
                i_in_valid <= 1'b0;
                repeat (n) @(negedge i_clk);
            end
            i_in_valid <= 1'b1;
            i_in_data  <= source_text[i];
            @(posedge i_clk);
            while (!o_in_ready) @(posedge i_clk);
            @(negedge i_clk);
        end
        i_in_valid <= 1'b0;

        // drain the remaining results, then allow a name-table walk
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
